>>> rtl/pwm_duty_ramp_generator_macros.svh
// Assertion macros used by the ramp generator top level.
`ifndef PWM_DUTY_RAMP_GENERATOR_MACROS_SVH
`define PWM_DUTY_RAMP_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PDR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pdr_pkg.sv
// Types and fixed constants of the PWM duty ramp generator.
package pdr_pkg;

	localparam int unsigned PCT_W   = 7;
	localparam int unsigned MS_W    = 16;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned CNT_W   = 10;
	localparam int unsigned PROD_W  = STEP_W + CNT_W;
	localparam int unsigned PCT_ENTRIES = 128;

	localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [MS_W-1:0]  MS_MAX    = 16'hFFFF;

	// input beat kinds
	localparam logic MODE_CMD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} pdr_state_t;

endpackage

>>> rtl/pdr_serial_div.sv
// Bit-serial restoring divider by an 8-bit divisor, one quotient bit per cycle.
module pdr_serial_div #(
	parameter int unsigned DIVIDEND_W = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIVIDEND_W-1:0]        dividend,
	input  logic [pdr_pkg::STEP_W-1:0]   divisor,
	output logic                         busy,
	output logic [DIVIDEND_W-1:0]        quotient
);

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

	logic [CNT_W-1:0]            steps_q;
	logic [DIVIDEND_W-1:0]       shift_q;
	logic [pdr_pkg::STEP_W-1:0]  rem_q;
	logic [pdr_pkg::STEP_W-1:0]  divisor_q;
	logic [pdr_pkg::STEP_W:0]    trial;
	logic [pdr_pkg::STEP_W:0]    trial_sub;
	logic                        fits;

	// one trial subtraction per cycle, next dividend bit shifted into the remainder
	assign trial     = {rem_q, shift_q[DIVIDEND_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign fits      = (trial >= {1'b0, divisor_q});

	assign busy     = (steps_q != '0);
	assign quotient = shift_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= CNT_W'(DIVIDEND_W);
		end else if (busy) begin
			steps_q <= steps_q - 1'b1;
		end
	end

	// dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy) begin
			shift_q <= {shift_q[DIVIDEND_W-2:0], fits};
			rem_q   <= fits ? trial_sub[pdr_pkg::STEP_W-1:0] : trial[pdr_pkg::STEP_W-1:0];
		end
	end

endmodule

>>> rtl/pwm_duty_ramp_generator.sv
// Top level of the PWM duty ramp generator: command decode, ramp state and output register.
//
//  channel | signals                                            | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid, in_ready, mode, start_pct, end_pct,      | in
//          | total_ms, step_count                               |
//  out     | out_valid, out_ready, compare_value, ramp_done     | out
//
// A command passes the accept cycle, the bit-serial total_ms / step_count divider (the percent
// divider runs beside it), a step to take both quotients and a step to load the output register.
// A tick that emits a value loads it after accept; either load stalls until a held result is taken.
// in_ready is high only while no beat is in progress; a result held in the
// output register does not block the next beat unless that beat has a result too.
// arst_n clears all ramp state and the output valid flag.
`include "pwm_duty_ramp_generator_macros.svh"

module pwm_duty_ramp_generator #(
	parameter int unsigned PWM_FULL_SCALE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [pdr_pkg::PCT_W-1:0]     start_pct,
	input  logic [pdr_pkg::PCT_W-1:0]     end_pct,
	input  logic [pdr_pkg::MS_W-1:0]      total_ms,
	input  logic [pdr_pkg::STEP_W-1:0]    step_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pdr_pkg::CNT_W-1:0]     compare_value,
	output logic                          ramp_done
);

	pdr_pkg::pdr_state_t state_q, state_nx;

	logic                          ramp_active_q;
	logic                          ramp_down_q;
	logic [pdr_pkg::STEP_W-1:0]    step_index_q;
	logic [pdr_pkg::STEP_W-1:0]    steps_total_q;
	logic [pdr_pkg::CNT_W-1:0]     count_increment_q;
	logic [pdr_pkg::CNT_W-1:0]     base_counts_q;
	logic [pdr_pkg::MS_W-1:0]      ms_per_step_q;
	logic [pdr_pkg::MS_W-1:0]      ms_elapsed_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [pdr_pkg::CNT_W-1:0]     compare_value_q;
	logic                          ramp_done_q;

	logic                          accept;
	logic                          cmd_ok;
	logic                          is_down;
	logic [pdr_pkg::PCT_W-1:0]     lo_pct;
	logic [pdr_pkg::PCT_W-1:0]     diff_pct;
	logic                          div_go;
	logic                          div_end;
	logic                          tick_go;
	logic                          load_out;
	logic                          div_t_busy;
	logic                          div_p_busy;
	logic [pdr_pkg::MS_W-1:0]      t_quot;
	logic [pdr_pkg::PCT_W-1:0]     p_quot;
	logic [pdr_pkg::MS_W-1:0]      elapsed_inc;
	logic                          tick_emit;
	logic [pdr_pkg::STEP_W-1:0]    idx_nx;
	logic                          done_nx;
	logic [pdr_pkg::PROD_W-1:0]    prod;
	logic [pdr_pkg::PROD_W:0]      sum;
	logic [pdr_pkg::CNT_W-1:0]     value_sat;
	logic [pdr_pkg::CNT_W-1:0]     cnt_tab [pdr_pkg::PCT_ENTRIES];

	// percent to compare counts, worked out at elaboration and saturated
	for (genvar p = 0; p < pdr_pkg::PCT_ENTRIES; p++) begin : g_tab
		localparam longint unsigned CNT = (longint'(p) * longint'(PWM_FULL_SCALE)) / 100;
		assign cnt_tab[p] = (CNT > longint'(pdr_pkg::COUNT_MAX)) ?
			pdr_pkg::COUNT_MAX : pdr_pkg::CNT_W'(CNT);
	end

	// command decode
	assign accept   = in_valid && in_ready;
	assign is_down  = (start_pct > end_pct);
	assign lo_pct   = is_down ? end_pct : start_pct;
	assign diff_pct = is_down ? (start_pct - end_pct) : (end_pct - start_pct);
	assign cmd_ok   = (mode == pdr_pkg::MODE_CMD) && (step_count != '0) &&
		(start_pct != end_pct);

	// tick: elapsed count and next step index
	assign elapsed_inc = (ms_elapsed_q < pdr_pkg::MS_MAX) ? (ms_elapsed_q + 1'b1) : ms_elapsed_q;
	assign tick_emit   = (elapsed_inc >= ms_per_step_q);
	always_comb begin
		if (ramp_down_q) begin
			idx_nx  = (step_index_q != '0) ? (step_index_q - 1'b1) : step_index_q;
			done_nx = (idx_nx == '0);
		end else begin
			idx_nx  = (step_index_q < steps_total_q) ? (step_index_q + 1'b1) : step_index_q;
			done_nx = (idx_nx >= steps_total_q);
		end
	end

	// step time and per-step percent, both divided by the step count
	pdr_serial_div #(.DIVIDEND_W(pdr_pkg::MS_W)) u_div_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (total_ms),
		.divisor  (step_count),
		.busy     (div_t_busy),
		.quotient (t_quot)
	);

	pdr_serial_div #(.DIVIDEND_W(pdr_pkg::PCT_W)) u_div_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (diff_pct),
		.divisor  (step_count),
		.busy     (div_p_busy),
		.quotient (p_quot)
	);

	// compare value: base plus index times increment, saturated
	assign prod      = pdr_pkg::PROD_W'(step_index_q) * pdr_pkg::PROD_W'(count_increment_q);
	assign sum       = {1'b0, prod} + (pdr_pkg::PROD_W + 1)'(base_counts_q);
	assign value_sat = (sum > (pdr_pkg::PROD_W + 1)'(pdr_pkg::COUNT_MAX)) ?
		pdr_pkg::COUNT_MAX : sum[pdr_pkg::CNT_W-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			pdr_pkg::ST_IDLE: begin
				if (div_go) begin
					state_nx = pdr_pkg::ST_DIV;
				end else if (tick_go && tick_emit) begin
					state_nx = pdr_pkg::ST_EMIT;
				end
			end
			pdr_pkg::ST_DIV: begin
				if (div_end) begin
					state_nx = pdr_pkg::ST_EMIT;
				end
			end
			pdr_pkg::ST_EMIT: begin
				if (load_out) begin
					state_nx = pdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = pdr_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		div_end  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			pdr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			pdr_pkg::ST_DIV: begin
				div_end = !div_t_busy && !div_p_busy;
			end
			pdr_pkg::ST_EMIT: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign div_go  = accept && cmd_ok;
	assign tick_go = accept && (mode == pdr_pkg::MODE_TICK) && ramp_active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ramp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_active_q     <= 1'b0;
			ramp_down_q       <= 1'b0;
			step_index_q      <= '0;
			steps_total_q     <= '0;
			count_increment_q <= '0;
			base_counts_q     <= '0;
			ms_per_step_q     <= '0;
			ms_elapsed_q      <= '0;
			last_q            <= 1'b0;
		end else begin
			if (div_go) begin
				ramp_down_q   <= is_down;
				base_counts_q <= cnt_tab[lo_pct];
				ms_elapsed_q  <= '0;
				steps_total_q <= step_count;
				ramp_active_q <= 1'b1;
				step_index_q  <= is_down ? step_count : pdr_pkg::STEP_W'(1);
				last_q        <= !is_down && (step_count == pdr_pkg::STEP_W'(1));
			end
			if (tick_go) begin
				if (tick_emit) begin
					ms_elapsed_q <= '0;
					step_index_q <= idx_nx;
					last_q       <= done_nx;
				end else begin
					ms_elapsed_q <= elapsed_inc;
				end
			end
			if (div_end) begin
				ms_per_step_q     <= t_quot;
				count_increment_q <= cnt_tab[p_quot];
			end
			if (load_out && last_q) begin
				ramp_active_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			compare_value_q <= value_sat;
			ramp_done_q     <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = compare_value_q;
	assign ramp_done     = ramp_done_q;

	// checks
	`PDR_ASSERT_NOW(a_idle_div_quiet, in_ready, !div_t_busy && !div_p_busy, "divider busy while accepting beats")
	`PDR_ASSERT_NOW(a_index_bound, ramp_active_q, step_index_q <= steps_total_q, "step index beyond step count")
	`PDR_ASSERT_NEXT(a_done_stops, load_out && last_q, !ramp_active_q, "ramp still active after final value")
	`PDR_ASSERT_NEXT(a_cmd_divides, div_go, (state_q == pdr_pkg::ST_DIV) && div_t_busy, "command did not start the dividers")

endmodule
